// ===== rtl/edf_pkg.sv =====
package edf_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 16;

    // configuration register map
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PACKED_WORDS = 4;
    localparam int FIELD_W      = 16;
    localparam int COUNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASKS_0_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TASKS_2_3  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TASKS_4_5  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TASKS_6_7  = 3'd4;

    localparam int TASK_NUM_W = 3;
    localparam int TDATA_W    = 8;

    typedef struct packed {
        logic accept;   // input transfer: clear scan, latch restart
        logic scan;     // evaluate the task at the scan index
        logic finish;   // charge the winner, load the result register
    } edf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } edf_status_t;

endpackage

// ===== rtl/edf_ctrl.sv =====
module edf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  edf_pkg::edf_status_t status,
    output edf_pkg::edf_cmd_t    cmd
);
    import edf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FINISH) && status.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (status.scan_last) state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold until the result register can take a new result
                    if (status.out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/edf_datapath.sv =====
module edf_datapath #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  edf_pkg::edf_cmd_t                cmd,
    output edf_pkg::edf_status_t             status,
    input  logic                             restart,
    input  logic                             cfg_write,
    input  logic [edf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [edf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [edf_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tuser
);
    import edf_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int FW    = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int CNT_W = 5;

    logic [COUNT_W-1:0]    task_count_reg;
    logic [CFG_DATA_W-1:0] task_words_reg [PACKED_WORDS];
    logic [TIME_BITS-1:0]  budget_reg [MAX_TASKS];
    logic [TIME_BITS-1:0]  phase_reg  [MAX_TASKS];

    logic [IDX_W-1:0]     idx_reg;
    logic                 restart_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_slack_reg;
    logic [TIME_BITS-1:0] best_budget_reg;

    logic                 m_tvalid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;
    logic                 m_tuser_reg;

    // per-task evaluation at the scan index
    logic [CNT_W-1:0]     count_sat;
    logic [4:0]           idx_ext;
    logic [CFG_DATA_W-1:0] word;
    logic [FIELD_W-1:0]   burst16;
    logic [FIELD_W-1:0]   period16;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] period;
    logic                 enabled;
    logic [TIME_BITS-1:0] b0;
    logic [TIME_BITS-1:0] p0;
    logic [TIME_BITS-1:0] bl_next;
    logic [TIME_BITS-1:0] ph_next;
    logic [TIME_BITS:0]   p_inc;
    logic [TIME_BITS-1:0] slack;
    logic                 take;

    always_comb begin
        count_sat = ({1'b0, task_count_reg} > CNT_W'(MAX_TASKS)) ?
                    CNT_W'(MAX_TASKS) : {1'b0, task_count_reg};
        idx_ext   = 5'(idx_reg);
        word      = task_words_reg[idx_ext[2:1]];
        burst16   = idx_ext[0] ? word[47:32] : word[15:0];
        period16  = idx_ext[0] ? word[63:48] : word[31:16];
        burst     = TIME_BITS'(burst16[FW-1:0]);
        period    = TIME_BITS'(period16[FW-1:0]);
        // tasks beyond the packed words have no configuration
        enabled   = (idx_ext[4:3] == 2'b00) && (CNT_W'(idx_reg) < count_sat)
                    && (period != '0);
        b0        = restart_reg ? '0 : budget_reg[idx_reg];
        p0        = restart_reg ? '0 : phase_reg[idx_reg];
        bl_next   = (p0 == '0) ? burst : b0;
        slack     = (p0 < period) ? (period - p0) : '0;
        p_inc     = {1'b0, p0} + (TIME_BITS+1)'(1);
        ph_next   = (p_inc >= {1'b0, period}) ? '0 : p_inc[TIME_BITS-1:0];
        take      = enabled && (bl_next != '0) && (!found_reg || slack < best_slack_reg);
        if (!enabled) begin
            bl_next = '0;
            ph_next = '0;
        end
    end

    assign status.scan_last = (idx_reg == IDX_W'(MAX_TASKS - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            for (int w = 0; w < PACKED_WORDS; w++) task_words_reg[w] <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TASK_COUNT: task_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_TASKS_0_1:  task_words_reg[0] <= cfg_data;
                REG_TASKS_2_3:  task_words_reg[1] <= cfg_data;
                REG_TASKS_4_5:  task_words_reg[2] <= cfg_data;
                REG_TASKS_6_7:  task_words_reg[3] <= cfg_data;
                default: ;  // drop writes beyond the register map
            endcase
        end
    end

    // task state and scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < MAX_TASKS; t++) begin
                budget_reg[t] <= '0;
                phase_reg[t]  <= '0;
            end
            idx_reg     <= '0;
            restart_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                idx_reg     <= '0;
                restart_reg <= restart;
                found_reg   <= 1'b0;
            end else if (cmd.scan) begin
                budget_reg[idx_reg] <= bl_next;
                phase_reg[idx_reg]  <= ph_next;
                idx_reg             <= idx_reg + IDX_W'(1);
                if (take) found_reg <= 1'b1;
            end else if (cmd.finish && found_reg) begin
                budget_reg[best_idx_reg] <= best_budget_reg - TIME_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            best_idx_reg <= '0;
        end else if (cmd.scan && take) begin
            best_idx_reg    <= idx_reg;
            best_slack_reg  <= slack;
            best_budget_reg <= bl_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tuser_reg <= !found_reg;
            m_tdata_reg <= TDATA_W'(TASK_NUM_W'(best_idx_reg));
        end
    end

endmodule

// ===== rtl/edf_periodic_task_scheduler.sv =====
// Channel  Ports                      Contents (lowest bit up)
// s_       s_tvalid s_tready s_tdata   restart
// m_       m_tvalid m_tready m_tdata   task_number ; m_tuser: idle
// cfg_     cfg_valid cfg_ready         cfg_index, cfg_data (64-bit register word)
//
// A tick takes the transfer, scans the tasks in turn with the single comparator that
// checks budgets and deadlines, and then charges the winner.
// Reset is synchronous, active low; budgets, phases, configuration and result valid clear.
// A waiting result holds in the output register; the scan of the next tick runs
// behind it and stalls in the finish state until the result is taken.
module edf_periodic_task_scheduler #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [edf_pkg::TDATA_W-1:0]    s_tdata,   // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [edf_pkg::TDATA_W-1:0]    m_tdata,   // [2:0] task_number
    output logic                           m_tuser,   // [0] idle
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [edf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import edf_pkg::*;

    edf_cmd_t    cmd;
    edf_status_t status;

    assign cfg_ready = 1'b1;

    edf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edf_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .restart   (s_tdata[0]),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/edf_checker.sv =====
module edf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tuser,
    input logic [edf_pkg::TDATA_W-1:0] m_tdata,
    input logic cfg_valid,
    input logic cfg_ready
);

    // a tick is in work after its transfer, so no second one right behind it
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken in the cycle after a transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_idle_number_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("idle result carries a task number");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // register writes land only while no tick is in work and no result waits
    a_cfg_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |-> (s_tready && !s_tvalid && !m_tvalid))
        else $error("register written while a tick is in flight");

endmodule

bind edf_periodic_task_scheduler edf_checker u_edf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== bench/edf_periodic_task_scheduler_tb.sv =====
module edf_periodic_task_scheduler_tb;
    import edf_pkg::*;

    localparam int NTASK           = MAX_TASKS_DEF;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int TICK_CYCLES     = NTASK + 2;
    localparam int ITEM_TARGET     = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = REG_TASKS_6_7 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    typedef struct {
        bit                  idle;
        bit [TASK_NUM_W-1:0] task_num;
    } grant_t;

    class edf_grant_scoreboard;
        logic [COUNT_W-1:0]    task_count;
        logic [CFG_DATA_W-1:0] task_words[PACKED_WORDS];
        logic [FIELD_W-1:0]    budget[NTASK];
        logic [FIELD_W-1:0]    phase[NTASK];
        grant_t                expected_grants[$];
        int mismatches, ticks, grants_seen, idle_seen, restarts;

        function new();
            task_count = '0;
            foreach (task_words[w]) task_words[w] = '0;
            foreach (budget[i]) begin
                budget[i] = '0;
                phase[i]  = '0;
            end
            mismatches  = 0;
            ticks       = 0;
            grants_seen = 0;
            idle_seen   = 0;
            restarts    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TASK_COUNT) begin
                task_count = data[COUNT_W-1:0];
            end else if (idx >= REG_TASKS_0_1 && idx <= REG_TASKS_6_7) begin
                task_words[idx - REG_TASKS_0_1] = data;
            end
        endfunction

        function logic [FIELD_W-1:0] burst_of(int i);
            return task_words[i / 2][(i % 2) * 32 +: FIELD_W];
        endfunction

        function logic [FIELD_W-1:0] period_of(int i);
            return task_words[i / 2][(i % 2) * 32 + FIELD_W +: FIELD_W];
        endfunction

        // Release, pick the nearest deadline, charge the winner, then advance phases.
        function void note_tick(bit restart);
            int     count;
            int     best;
            int     best_slack;
            int     slack;
            bit     found;
            grant_t g;
            logic [FIELD_W-1:0] period;
            count = (task_count > NTASK) ? NTASK : int'(task_count);
            ticks++;
            if (restart) begin
                restarts++;
                foreach (budget[i]) begin
                    budget[i] = '0;
                    phase[i]  = '0;
                end
            end
            found      = 1'b0;
            best       = 0;
            best_slack = 0;
            for (int i = 0; i < NTASK; i++) begin
                period = period_of(i);
                if (i >= count || period == 0) begin
                    budget[i] = '0;
                    phase[i]  = '0;
                end else begin
                    if (phase[i] == 0) budget[i] = burst_of(i);
                    slack = (phase[i] < period) ? int'(period) - int'(phase[i]) : 0;
                    if (budget[i] != 0 && (!found || slack < best_slack)) begin
                        found      = 1'b1;
                        best       = i;
                        best_slack = slack;
                    end
                end
            end
            if (found) begin
                budget[best] = budget[best] - 1'b1;
                g.idle       = 1'b0;
                g.task_num   = best[TASK_NUM_W-1:0];
            end else begin
                g.idle     = 1'b1;
                g.task_num = '0;
            end
            for (int i = 0; i < count; i++) begin
                period = period_of(i);
                if (period != 0) begin
                    if (int'(phase[i]) + 1 >= int'(period)) phase[i] = '0;
                    else phase[i] = phase[i] + 1'b1;
                end
            end
            expected_grants.push_back(g);
        endfunction

        function void check_grant(bit idle, bit [TASK_NUM_W-1:0] task_num);
            grant_t g;
            if (expected_grants.size() == 0) begin
                $error("unexpected result transfer: idle=%0d task_number=%0d", idle, task_num);
                mismatches++;
                return;
            end
            g = expected_grants.pop_front();
            grants_seen++;
            if (idle) idle_seen++;
            if (idle != g.idle) begin
                $error("idle mismatch: expected %0d, got %0d", g.idle, idle);
                mismatches++;
            end
            if (task_num != g.task_num) begin
                $error("task_number mismatch: expected %0d, got %0d", g.task_num, task_num);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edf_grant_scoreboard sb;
    int  cycle_count  = 0;
    int  sink_stall   = 0;
    int  settings     = 0;
    bit  no_idle      = 1'b0;
    bit  hold_off_req = 1'b0;

    edf_periodic_task_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return FIELD_W'($urandom_range(13, 65535));
        return FIELD_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return FIELD_W'($urandom);
        return FIELD_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] task_pair(logic [FIELD_W-1:0] b0,
            logic [FIELD_W-1:0] p0, logic [FIELD_W-1:0] b1, logic [FIELD_W-1:0] p1);
        return {p1, b1, p0, b0};
    endfunction

    // Sink: random stalls after each transfer, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                sink_stall   = 0;
            end
            m_tready <= (sink_stall == 0);
            if (sink_stall > 0) sink_stall--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_grant(m_tuser, m_tdata[TASK_NUM_W-1:0]);
            sink_stall = pick_gap();
        end
    end

    task automatic send_tick(bit restart, int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - 1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(restart);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pause_sender();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Drain all results, then let a full tick pass before touching registers.
    task automatic wait_idle();
        pause_sender();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TICK_CYCLES + 2) @(posedge aclk);
    endtask

    task automatic load_random_setting();
        logic [FIELD_W-1:0]    bursts[NTASK];
        logic [FIELD_W-1:0]    periods[NTASK];
        logic [CFG_DATA_W-1:0] word;
        int r;
        foreach (bursts[i]) begin
            periods[i] = pick_period();
            bursts[i]  = pick_burst();
        end
        if ($urandom_range(0, 4) != 0) begin
            word = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) word = '0;
            r = $urandom_range(0, 9);
            if (r == 0) word[COUNT_W-1:0] = '0;
            else if (r == 1) word[COUNT_W-1:0] = COUNT_W'($urandom_range(NTASK + 1, 15));
            else word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, NTASK));
            write_reg(REG_TASK_COUNT, word);
        end
        for (int w = 0; w < PACKED_WORDS; w++) begin
            if ($urandom_range(0, 4) != 0) begin
                write_reg(CFG_IDX_W'(REG_TASKS_0_1 + w),
                          task_pair(bursts[2 * w], periods[2 * w],
                                    bursts[2 * w + 1], periods[2 * w + 1]));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                      {$urandom, $urandom});
        end
        settings++;
    endtask

    initial begin
        int  n_items;
        bit  pressure;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: no tasks in use
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        wait_idle();

        // disabled task, zero burst, largest burst and period, tied deadlines
        write_reg(REG_TASK_COUNT, CFG_DATA_W'(NTASK));
        write_reg(REG_TASKS_0_1, task_pair(16'd3, 16'd0, 16'd0, 16'd5));
        write_reg(REG_TASKS_2_3, task_pair(16'hFFFF, 16'hFFFF, 16'd2, 16'd4));
        write_reg(REG_TASKS_4_5, task_pair(16'd2, 16'd4, 16'd1, 16'd1));
        write_reg(REG_TASKS_6_7, task_pair(16'd3, 16'd7, 16'd1, 16'd2));
        settings++;
        for (int k = 0; k < 12; k++) send_tick(k == 0 || k == 6, 0);
        wait_idle();

        // shrink a period under the running phase, oversize count, unmapped writes
        write_reg(REG_TASKS_2_3, task_pair(16'd2, 16'd3, 16'hFFFF, 16'd1));
        write_reg(REG_TASK_COUNT, CFG_DATA_W'(15));
        write_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
        write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        settings++;
        for (int k = 0; k < 8; k++) send_tick(1'b0, k % 3);
        wait_idle();

        // junk above the count field must be ignored
        write_reg(REG_TASK_COUNT, {{(CFG_DATA_W - COUNT_W){1'b1}}, 4'd3});
        settings++;
        for (int k = 0; k < 3; k++) send_tick(1'b0, 0);
        wait_idle();

        for (int ph = 0; sb.ticks < ITEM_TARGET; ph++) begin
            load_random_setting();
            n_items  = $urandom_range(40, 140);
            pressure = (ph == 2);
            no_idle  = pressure || ($urandom_range(0, 3) == 0);
            if (pressure) hold_off_req = 1'b1;
            for (int k = 0; k < n_items; k++) begin
                // halfway through the stalled phase, hold input until all results are back
                if (pressure && k == n_items / 2) begin
                    pause_sender();
                    while (sb.pending() != 0) @(posedge aclk);
                end
                send_tick($urandom_range(0, 31) == 0, pick_gap());
            end
            wait_idle();
            no_idle = 1'b0;
        end

        $display("Ran %0d ticks (%0d with restart) across %0d register settings.",
                 sb.ticks, sb.restarts, settings);
        $display("Checked %0d results, %0d idle; long output hold-off and drain pause done.",
                 sb.grants_seen, sb.idle_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
